// ===== src/tilt_bar_frame_engine_core_defines.svh =====
// ---------------------------------------------------------------------------
// Tilt bar frame engine: assertion macros
// Concurrent checks clocked on clk and disabled while rst_n is low. In a
// synthesis build they expand to nothing.
// ---------------------------------------------------------------------------
`ifndef TILT_BAR_FRAME_ENGINE_CORE_DEFINES_SVH
`define TILT_BAR_FRAME_ENGINE_CORE_DEFINES_SVH

`ifndef SYNTH
// plain property
`define TBFE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// same-cycle implication
`define TBFE_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define TBFE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TBFE_ASSERT(lbl, prop, msg)
`define TBFE_ASSERT_IMPL(lbl, ante, cons, msg)
`define TBFE_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== src/tbfe_pkg.sv =====
// ---------------------------------------------------------------------------
// Tilt bar frame engine package
// Shared constants, request codes, command and frame types.
// ---------------------------------------------------------------------------
`default_nettype none

package tbfe_pkg;

    // default number of chained matrices
    localparam int DEVICES_DEF = 4;
    // command queue depth between front and back
    localparam int QDEPTH = 2;
    // tilt sum divisor
    localparam int BAR_DIV = 6;
    // lines (rows / columns) per matrix
    localparam int LINES = 8;

    // request codes; code 3 means nothing and is dropped
    typedef enum logic [1:0] {
        REQ_DRAW    = 2'd0,
        REQ_CLEAR   = 2'd1,
        REQ_REFRESH = 2'd2
    } req_t;

    // back end sequencer
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DRAW_RD,
        ST_DRAW_LOAD,
        ST_DRAW_LINE,
        ST_DRAW_WB,
        ST_REFRESH,
        ST_REF_DRAIN
    } bstate_t;

    // one matrix: [row][bit]
    typedef logic [7:0][7:0] frame_t;

    // classified command held in the queue
    typedef struct packed {
        req_t               op;
        logic signed [15:0] tilt_x;
        logic signed [15:0] tilt_y;
        logic [1:0]         wall_side;
        logic [2:0]         dev;
        logic               rows;
        logic               invert;
        logic               reverse;
    } cmd_t;

    // index width for a count of n, at least one bit
    function automatic int idx_w(input int n);
        int w;
        w = (n > 1) ? $clog2(n) : 1;
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== src/tbfe_req_if.sv =====
// ---------------------------------------------------------------------------
// Tilt bar frame engine request channel
// Valid/ready channel carrying one draw, clear or refresh request.
// ---------------------------------------------------------------------------
`default_nettype none

interface tbfe_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         req_type;
    logic signed [15:0] tilt_x;
    logic signed [15:0] tilt_y;
    logic [1:0]         wall_side;
    logic [2:0]         display_index;
    logic               bars_in_rows;
    logic               invert_fill;
    logic               reverse_order;

    modport source (
        output valid, req_type, tilt_x, tilt_y, wall_side, display_index,
               bars_in_rows, invert_fill, reverse_order,
        input  ready
    );
    modport sink (
        input  valid, req_type, tilt_x, tilt_y, wall_side, display_index,
               bars_in_rows, invert_fill, reverse_order,
        output ready
    );
endinterface

`default_nettype wire

// ===== src/tbfe_word_if.sv =====
// ---------------------------------------------------------------------------
// Tilt bar frame engine word channel
// Valid/ready channel carrying one serial word of a refresh.
// ---------------------------------------------------------------------------
`default_nettype none

interface tbfe_word_if;
    logic        valid;
    logic        ready;
    logic [15:0] serial_word;
    logic        frame_end;
    logic        last;

    modport source (
        output valid, serial_word, frame_end, last,
        input  ready
    );
    modport sink (
        input  valid, serial_word, frame_end, last,
        output ready
    );
endinterface

`default_nettype wire

// ===== src/tilt_bar_frame_engine_core.sv =====
// ---------------------------------------------------------------------------
// Tilt bar frame engine core
// Keeps one 8x8 bit frame per chained LED matrix (DEVICES of them).
// Channel req (valid/ready) takes draw, clear and refresh requests; draws
// to a display at or above DEVICES and request code 3 are taken and dropped.
// Channel word (valid/ready) gives the refresh words: rows 0..7, highest
// device first, frame_end on device 0, last on the final word.
// A request goes through a two-entry queue to the back-end sequencer.
// A draw holds the sequencer through pop, frame read, load, eight
// lines through a two-stage multiply and bar unit, and write back; a clear
// does not leave the idle state. A refresh gives 8*DEVICES words while the
// receiver is ready, the first through the queue, the frame read and the
// output register when the sequencer is free; the single read port of the
// frame memory allows one read in flight, which sets the pace.
// Reset clears all frames, the queue and the output register.
// When the receiver stalls the word holds; queued requests wait behind it
// and req.ready drops once the queue is full.
// ---------------------------------------------------------------------------
`default_nettype none

module tilt_bar_frame_engine_core #(
    parameter int DEVICES = tbfe_pkg::DEVICES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    tbfe_req_if.sink    req,
    tbfe_word_if.source word
);
    import tbfe_pkg::*;

    logic q_full;
    logic push;
    cmd_t push_cmd;
    logic q_valid;
    cmd_t q_data;
    logic pop;

    // classify and enqueue
    tbfe_front #(
        .DEVICES (DEVICES)
    ) u_front (
        .req      (req),
        .q_full   (q_full),
        .push     (push),
        .push_cmd (push_cmd)
    );

    // decoupling queue
    tbfe_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .q_valid  (q_valid),
        .q_data   (q_data),
        .pop      (pop)
    );

    // execute against the frame memory
    tbfe_back #(
        .DEVICES (DEVICES)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_data  (q_data),
        .pop     (pop),
        .word    (word)
    );

endmodule

`default_nettype wire

// ===== src/tbfe_front.sv =====
// ---------------------------------------------------------------------------
// Tilt bar frame engine front end
// Takes request transfers, drops unknown codes and draws to absent
// displays, and pushes the rest into the command queue.
// ---------------------------------------------------------------------------
`default_nettype none

module tbfe_front #(
    parameter int DEVICES = tbfe_pkg::DEVICES_DEF
) (
    tbfe_req_if.sink       req,
    input  logic           q_full,
    output logic           push,
    output tbfe_pkg::cmd_t push_cmd
);
    import tbfe_pkg::*;

    localparam logic [3:0] DEV_LIM = 4'(DEVICES);

    logic keep;

    // accept whenever the queue has room; dropped items just vanish
    assign req.ready = !q_full;

    // classify
    always_comb
    begin
        keep = 1'b0;
        if (req.req_type == REQ_DRAW)
        begin
            keep = ({1'b0, req.display_index} < DEV_LIM);
        end
        else if (req.req_type == REQ_CLEAR || req.req_type == REQ_REFRESH)
        begin
            keep = 1'b1;
        end
    end

    assign push = req.valid && req.ready && keep;

    // pack the command
    always_comb
    begin
        push_cmd.op        = req_t'(req.req_type);
        push_cmd.tilt_x    = req.tilt_x;
        push_cmd.tilt_y    = req.tilt_y;
        push_cmd.wall_side = req.wall_side;
        push_cmd.dev       = req.display_index;
        push_cmd.rows      = req.bars_in_rows;
        push_cmd.invert    = req.invert_fill;
        push_cmd.reverse   = req.reverse_order;
    end

endmodule

`default_nettype wire

// ===== src/tbfe_queue.sv =====
// ---------------------------------------------------------------------------
// Tilt bar frame engine command queue
// Short FIFO that decouples the front end from the back end.
// ---------------------------------------------------------------------------
`default_nettype none

module tbfe_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  tbfe_pkg::cmd_t push_cmd,
    output logic           full,
    output logic           q_valid,
    output tbfe_pkg::cmd_t q_data,
    input  logic           pop
);
    import tbfe_pkg::*;

    localparam int PTR_W = idx_w(QDEPTH);
    localparam int CNT_W = $clog2(QDEPTH + 1);

    cmd_t             slot_reg [QDEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;

    assign full    = (count_reg == CNT_W'(QDEPTH));
    assign q_valid = (count_reg != '0);
    assign q_data  = slot_reg[rd_ptr_reg];

    // pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage, no reset
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== src/tbfe_back.sv =====
// ---------------------------------------------------------------------------
// Tilt bar frame engine back end
// Sequencer over the frame memory: draws bars one line a cycle, clears
// the store and streams refresh words through a registered output.
// ---------------------------------------------------------------------------
`default_nettype none
`include "tilt_bar_frame_engine_core_defines.svh"

module tbfe_back #(
    parameter int DEVICES = tbfe_pkg::DEVICES_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    input  tbfe_pkg::cmd_t q_data,
    output logic           pop,
    tbfe_word_if.source    word
);
    import tbfe_pkg::*;

    localparam int DEV_W = idx_w(DEVICES);
    localparam int S_W   = 21;

    // bar height from the tilt sum: 4 + trunc(s/6), clamped to 0..8 before inversion
    function automatic logic [3:0] bar_code(input logic signed [S_W-1:0] s,
                                            input logic inv);
        logic [3:0] up;
        logic [3:0] dn;
        logic [3:0] h;
        up = '0;
        dn = '0;
        for (int k = 1; k <= 4; k++)
        begin
            if (s >= S_W'(BAR_DIV * k))
            begin
                up = up + 1'b1;
            end
            if (s <= -S_W'(BAR_DIV * k))
            begin
                dn = dn + 1'b1;
            end
        end
        h = 4'd4 + up - dn;
        // partial bars fill from the far end
        if (inv && h != 4'd0 && h != 4'd8)
        begin
            h = 4'd0 - h;
        end
        return h;
    endfunction

    // codes up to 8 set the low bits, 9..15 the bits from code-8 upwards
    function automatic logic [7:0] bar_mask(input logic [3:0] code);
        logic [7:0] m;
        if (code <= 4'd8)
        begin
            m = 8'((9'd1 << code) - 9'd1);
        end
        else
        begin
            m = 8'(9'h0FF << (code - 4'd8));
        end
        return m;
    endfunction

    bstate_t              state_reg, state_next;
    cmd_t                 cmd_reg, cmd_next;
    logic [3:0]           cnt_reg, cnt_next;
    logic signed [19:0]   prod_x_reg, prod_x_next;
    logic signed [19:0]   prod_y_reg, prod_y_next;
    logic [2:0]           prod_line_reg, prod_line_next;
    logic                 prod_valid_reg, prod_valid_next;
    frame_t               work_reg, work_next;
    logic [DEVICES-1:0]   valid_reg, valid_next;
    logic                 rvalid_reg;
    logic [2:0]           row_cnt_reg, row_cnt_next;
    logic [DEV_W-1:0]     dev_cnt_reg, dev_cnt_next;
    logic                 rd_pend_reg, rd_pend_next;
    logic [2:0]           pend_row_reg, pend_row_next;
    logic                 pend_fe_reg, pend_fe_next;
    logic                 pend_last_reg, pend_last_next;
    logic                 out_valid_reg, out_valid_next;
    logic [15:0]          out_word_reg, out_word_next;
    logic                 out_fe_reg, out_fe_next;
    logic                 out_last_reg, out_last_next;

    frame_t               mem [DEVICES];
    frame_t               rdata_reg;
    frame_t               rframe;
    logic [DEV_W-1:0]     raddr;
    logic                 mem_we;
    logic                 issue;
    logic                 ref_last;
    logic [2:0]           line;
    logic signed [4:0]    mpos;
    logic signed [3:0]    m4;
    logic signed [3:0]    cx, cy;
    logic signed [S_W-1:0] tsum;
    logic [7:0]           mask;

    // a never-written or cleared frame reads as zero
    assign rframe = rvalid_reg ? rdata_reg : '0;

    assign pop   = (state_reg == ST_IDLE) && q_valid;
    assign issue = (state_reg == ST_REFRESH) && !rd_pend_reg
                   && (!out_valid_reg || word.ready);
    assign ref_last = (row_cnt_reg == 3'd7) && (dev_cnt_reg == '0);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    unique case (q_data.op)
                        REQ_DRAW:    state_next = ST_DRAW_RD;
                        REQ_REFRESH: state_next = ST_REFRESH;
                        default:     state_next = ST_IDLE;
                    endcase
                end
            end
            ST_DRAW_RD:   state_next = ST_DRAW_LOAD;
            ST_DRAW_LOAD: state_next = ST_DRAW_LINE;
            ST_DRAW_LINE:
            begin
                if (cnt_reg == 4'd8)
                begin
                    state_next = ST_DRAW_WB;
                end
            end
            ST_DRAW_WB:   state_next = ST_IDLE;
            ST_REFRESH:
            begin
                if (issue && ref_last)
                begin
                    state_next = ST_REF_DRAIN;
                end
            end
            ST_REF_DRAIN: state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // line position and rotation for the line being multiplied
    always_comb
    begin
        line = cnt_reg[2:0];
        mpos = $signed({1'b0, line, 1'b0}) - 5'sd7;
        m4   = cmd_reg.reverse ? -mpos[3:0] : mpos[3:0];
        unique case (cmd_reg.wall_side)
            2'd0:    begin cx = m4;     cy = 4'sd7;  end
            2'd1:    begin cx = 4'sd7;  cy = -m4;    end
            2'd2:    begin cx = -m4;    cy = -4'sd7; end
            default: begin cx = -4'sd7; cy = m4;     end
        endcase
    end

    // bar of the line whose products are registered
    always_comb
    begin
        tsum = S_W'(prod_x_reg) + S_W'(prod_y_reg);
        mask = bar_mask(bar_code(tsum, cmd_reg.invert));
    end

    // datapath and outputs
    always_comb
    begin
        cmd_next        = cmd_reg;
        cnt_next        = cnt_reg;
        prod_x_next     = prod_x_reg;
        prod_y_next     = prod_y_reg;
        prod_line_next  = prod_line_reg;
        prod_valid_next = 1'b0;
        work_next       = work_reg;
        valid_next      = valid_reg;
        row_cnt_next    = row_cnt_reg;
        dev_cnt_next    = dev_cnt_reg;
        rd_pend_next    = 1'b0;
        pend_row_next   = pend_row_reg;
        pend_fe_next    = pend_fe_reg;
        pend_last_next  = pend_last_reg;
        out_valid_next  = out_valid_reg && !word.ready;
        out_word_next   = out_word_reg;
        out_fe_next     = out_fe_reg;
        out_last_next   = out_last_reg;
        raddr           = dev_cnt_reg;
        mem_we          = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (pop)
                begin
                    cmd_next     = q_data;
                    row_cnt_next = '0;
                    dev_cnt_next = DEV_W'(DEVICES - 1);
                    if (q_data.op == REQ_CLEAR)
                    begin
                        valid_next = '0;
                    end
                end
            end
            ST_DRAW_RD:
            begin
                raddr = cmd_reg.dev[DEV_W-1:0];
            end
            ST_DRAW_LOAD:
            begin
                work_next = rframe;
                cnt_next  = '0;
            end
            ST_DRAW_LINE:
            begin
                // multiply for this line, apply the previous one
                if (cnt_reg != 4'd8)
                begin
                    prod_x_next     = 20'(cmd_reg.tilt_x) * 20'(cx);
                    prod_y_next     = 20'(cmd_reg.tilt_y) * 20'(cy);
                    prod_line_next  = line;
                    prod_valid_next = 1'b1;
                    cnt_next        = cnt_reg + 1'b1;
                end
                if (prod_valid_reg)
                begin
                    if (cmd_reg.rows)
                    begin
                        work_next[prod_line_reg] = mask;
                    end
                    else
                    begin
                        for (int r = 0; r < LINES; r++)
                        begin
                            work_next[r][prod_line_reg] = mask[r];
                        end
                    end
                end
            end
            ST_DRAW_WB:
            begin
                mem_we = 1'b1;
                valid_next[cmd_reg.dev[DEV_W-1:0]] = 1'b1;
            end
            ST_REFRESH:
            begin
                if (issue)
                begin
                    rd_pend_next   = 1'b1;
                    pend_row_next  = row_cnt_reg;
                    pend_fe_next   = (dev_cnt_reg == '0);
                    pend_last_next = ref_last;
                    if (dev_cnt_reg == '0)
                    begin
                        dev_cnt_next = DEV_W'(DEVICES - 1);
                        row_cnt_next = row_cnt_reg + 1'b1;
                    end
                    else
                    begin
                        dev_cnt_next = dev_cnt_reg - 1'b1;
                    end
                end
            end
            ST_REF_DRAIN:
            begin
            end
            default:
            begin
            end
        endcase

        // read data is back: fill the output register
        if (rd_pend_reg)
        begin
            out_valid_next = 1'b1;
            out_word_next  = {8'(pend_row_reg) + 8'd1, rframe[pend_row_reg]};
            out_fe_next    = pend_fe_reg;
            out_last_next  = pend_last_reg;
        end
    end

    assign word.valid       = out_valid_reg;
    assign word.serial_word = out_word_reg;
    assign word.frame_end   = out_fe_reg;
    assign word.last        = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cmd_reg        <= '0;
            cnt_reg        <= '0;
            prod_x_reg     <= '0;
            prod_y_reg     <= '0;
            prod_line_reg  <= '0;
            prod_valid_reg <= 1'b0;
            work_reg       <= '0;
            valid_reg      <= '0;
            rvalid_reg     <= 1'b0;
            row_cnt_reg    <= '0;
            dev_cnt_reg    <= '0;
            rd_pend_reg    <= 1'b0;
            pend_row_reg   <= '0;
            pend_fe_reg    <= 1'b0;
            pend_last_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_word_reg   <= '0;
            out_fe_reg     <= 1'b0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cmd_reg        <= cmd_next;
            cnt_reg        <= cnt_next;
            prod_x_reg     <= prod_x_next;
            prod_y_reg     <= prod_y_next;
            prod_line_reg  <= prod_line_next;
            prod_valid_reg <= prod_valid_next;
            work_reg       <= work_next;
            valid_reg      <= valid_next;
            rvalid_reg     <= valid_reg[raddr];
            row_cnt_reg    <= row_cnt_next;
            dev_cnt_reg    <= dev_cnt_next;
            rd_pend_reg    <= rd_pend_next;
            pend_row_reg   <= pend_row_next;
            pend_fe_reg    <= pend_fe_next;
            pend_last_reg  <= pend_last_next;
            out_valid_reg  <= out_valid_next;
            out_word_reg   <= out_word_next;
            out_fe_reg     <= out_fe_next;
            out_last_reg   <= out_last_next;
        end
    end

    // frame memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[cmd_reg.dev[DEV_W-1:0]] <= work_reg;
        end
        rdata_reg <= mem[raddr];
    end

    // a returning read never lands on a word still waiting
    `TBFE_ASSERT_IMPL(a_pend_slot_free, rd_pend_reg, !out_valid_reg, "read return over busy output")
    // products only exist while lines are being drawn
    `TBFE_ASSERT_IMPL(a_prod_in_draw, prod_valid_reg, state_reg == ST_DRAW_LINE, "stray product")
    // final word of a refresh also closes its row frame
    `TBFE_ASSERT_IMPL(a_last_is_fe, out_valid_reg && out_last_reg, out_fe_reg, "last without frame end")
    // clear empties every frame at once
    `TBFE_ASSERT_NEXT(a_clear_all, pop && q_data.op == REQ_CLEAR, valid_reg == '0, "clear missed a frame")

endmodule

`default_nettype wire

// ===== dv/tilt_bar_frame_engine_core_test.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Tilt bar frame engine core testbench
// Drives draw, clear and refresh requests into the core and keeps its own
// copy of the LED frames. Every refresh is expanded into the serial words it
// must produce, and each word from the core is checked against the oldest of
// those. Sender and receiver idle at random in three settings of pressure.
// ---------------------------------------------------------------------------

module tilt_bar_frame_engine_core_test;
    import tbfe_pkg::*;

    localparam int DEVICES = DEVICES_DEF;
    // request code with no meaning; the core takes and drops it
    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int REPORT_MAX = 10;

    typedef struct {
        logic [1:0]         kind;
        logic signed [15:0] tilt_x;
        logic signed [15:0] tilt_y;
        logic [1:0]         side;
        logic [2:0]         disp;
        logic               rows;
        logic               invert;
        logic               reverse;
    } request_t;

    typedef struct {
        logic [15:0] serial_word;
        logic        frame_end;
        logic        last;
    } refresh_word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    tbfe_req_if  req_ch ();
    tbfe_word_if word_ch ();

    tilt_bar_frame_engine_core #(
        .DEVICES(DEVICES)
    ) DUT (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_ch),
        .word (word_ch)
    );

    // predicted frames: [device][row], bit i is column i
    logic [7:0] frame_copy [DEVICES][8];
    refresh_word_t refresh_words_due [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int failures = 0;
    int words_checked = 0;
    int draws_sent = 0;
    int clears_sent = 0;
    int refreshes_sent = 0;
    int dropped_sent = 0;

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // -----------------------------------------------------------------------
    // Predictor
    // -----------------------------------------------------------------------

    // bar code to mask: 0..8 fills from the bottom, 9..15 from c-8 to the top
    function automatic logic [7:0] bar_bits(input int code);
        logic [7:0] bits;
        if (code <= 0)
            bits = 8'h00;
        else if (code <= 8)
            bits = 8'((9'd1 << code) - 9'd1);
        else if (code < 16)
            bits = 8'(8'hFF << (code - 8));
        else
            bits = 8'h00;
        return bits;
    endfunction

    // bar height for one line position after rotation by the wall side
    function automatic int bar_code(input request_t r, input int line);
        int pos;
        int cx;
        int cy;
        int h;
        pos = 2 * line - 7;
        if (r.reverse)
            pos = -pos;
        case (r.side)
            2'd0:    begin cx = pos; cy = 7;    end
            2'd1:    begin cx = 7;   cy = -pos; end
            2'd2:    begin cx = -pos; cy = -7;  end
            default: begin cx = -7;  cy = pos;  end
        endcase
        // int division truncates towards zero
        h = 4 + (int'(r.tilt_x) * cx + int'(r.tilt_y) * cy) / BAR_DIV;
        if (h < 0)
            h = 0;
        if (h > 8)
            h = 8;
        if (r.invert && h > 0 && h < 8)
            h = 16 - h;
        return h;
    endfunction

    task automatic draw_bars(input request_t r);
        logic [7:0] bits;
        if (r.disp >= DEVICES)
            return;
        for (int line = 0; line < LINES; line++)
        begin
            bits = bar_bits(bar_code(r, line));
            if (r.rows)
                frame_copy[r.disp][line] = bits;
            else
                for (int row = 0; row < LINES; row++)
                    frame_copy[r.disp][row][line] = bits[row];
        end
    endtask

    // update the frame copy, or queue the words a refresh must give
    task automatic predict_request(input request_t r);
        refresh_word_t w;
        case (r.kind)
            REQ_DRAW:
            begin
                draws_sent++;
                draw_bars(r);
            end
            REQ_CLEAR:
            begin
                clears_sent++;
                foreach (frame_copy[d, row])
                    frame_copy[d][row] = 8'h00;
            end
            REQ_REFRESH:
            begin
                refreshes_sent++;
                for (int row = 0; row < LINES; row++)
                    for (int d = DEVICES - 1; d >= 0; d--)
                    begin
                        w.serial_word = {8'(row + 1), frame_copy[d][row]};
                        w.frame_end = (d == 0);
                        w.last = (d == 0) && (row == LINES - 1);
                        refresh_words_due.push_back(w);
                    end
            end
            default:
                dropped_sent++;
        endcase
    endtask

    // -----------------------------------------------------------------------
    // Request side
    // -----------------------------------------------------------------------

    // entered and left just after a falling edge
    task automatic send_request(input request_t r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid = 1'b0;
            @(negedge clk);
        end
        req_ch.valid = 1'b1;
        req_ch.req_type = r.kind;
        req_ch.tilt_x = r.tilt_x;
        req_ch.tilt_y = r.tilt_y;
        req_ch.wall_side = r.side;
        req_ch.display_index = r.disp;
        req_ch.bars_in_rows = r.rows;
        req_ch.invert_fill = r.invert;
        req_ch.reverse_order = r.reverse;
        do
            @(posedge clk);
        while (!req_ch.ready);
        predict_request(r);
        @(negedge clk);
    endtask

    function automatic request_t make_request(input logic [1:0] kind,
                                              input logic signed [15:0] tx,
                                              input logic signed [15:0] ty,
                                              input logic [1:0] side,
                                              input logic [2:0] disp,
                                              input logic rows,
                                              input logic invert,
                                              input logic reverse);
        request_t r;
        r.kind = kind;
        r.tilt_x = tx;
        r.tilt_y = ty;
        r.side = side;
        r.disp = disp;
        r.rows = rows;
        r.invert = invert;
        r.reverse = reverse;
        return r;
    endfunction

    // tilt mix: full-range random, small and extreme values; small ones give partial bars
    function automatic logic signed [15:0] random_tilt();
        logic signed [15:0] t;
        case ($urandom_range(3))
            0:       t = 16'($urandom);
            1:       t = 16'(int'($urandom_range(60)) - 30);
            2:       t = 16'(int'($urandom_range(8)) - 4);
            default:
                case ($urandom_range(3))
                    0:       t = 16'sh7FFF;
                    1:       t = -16'sh8000;
                    2:       t = 16'sh0000;
                    default: t = -16'sh0001;
                endcase
        endcase
        return t;
    endfunction

    function automatic request_t random_request();
        request_t r;
        int pick;
        pick = $urandom_range(99);
        r = make_request(REQ_DRAW, random_tilt(), random_tilt(), 2'($urandom),
                         3'($urandom_range(DEVICES - 1)), 1'($urandom),
                         1'($urandom), 1'($urandom));
        if (pick < 8)
            r.disp = 3'($urandom_range(7, DEVICES));
        else if (pick < 70)
            r.kind = REQ_DRAW;
        else if (pick < 75)
            r.kind = REQ_CLEAR;
        else if (pick < 95)
            r.kind = REQ_REFRESH;
        else
            r.kind = REQ_UNUSED;
        return r;
    endfunction

    // -----------------------------------------------------------------------
    // Word side: ready changes at the falling edge, transfers checked at the
    // rising edge
    // -----------------------------------------------------------------------
    always @(negedge clk)
        word_ch.ready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk)
    begin : check_words
        refresh_word_t due;
        if (rst_n && word_ch.valid && word_ch.ready)
        begin
            if (refresh_words_due.size() == 0)
            begin
                failures++;
                if (failures <= REPORT_MAX)
                    $display("%0t: word %h (frame_end %b last %b) with none due",
                             $realtime, word_ch.serial_word, word_ch.frame_end,
                             word_ch.last);
            end
            else
            begin
                due = refresh_words_due.pop_front();
                words_checked++;
                if (word_ch.serial_word !== due.serial_word ||
                    word_ch.frame_end !== due.frame_end ||
                    word_ch.last !== due.last)
                begin
                    failures++;
                    if (failures <= REPORT_MAX)
                        $display("%0t: word %h/%b/%b, expected %h/%b/%b", $realtime,
                                 word_ch.serial_word, word_ch.frame_end, word_ch.last,
                                 due.serial_word, due.frame_end, due.last);
                end
            end
        end
    end

    // -----------------------------------------------------------------------
    // Tests
    // -----------------------------------------------------------------------

    // frames are zero straight after reset
    task automatic test_refresh_after_reset();
        send_request(make_request(REQ_REFRESH, 0, 0, 0, 0, 0, 0, 0));
    endtask

    // full-scale tilts drive most bars empty or full; one wall side and mode per device
    task automatic test_full_tilt_bars();
        send_request(make_request(REQ_DRAW, 16'sh7FFF, 16'sh7FFF, 2'd0, 3'd0, 0, 0, 0));
        send_request(make_request(REQ_DRAW, -16'sh8000, -16'sh8000, 2'd1, 3'd1, 1, 1, 0));
        send_request(make_request(REQ_DRAW, 16'sh7FFF, -16'sh8000, 2'd2, 3'd2, 0, 1, 1));
        send_request(make_request(REQ_DRAW, -16'sh8000, 16'sh7FFF, 2'd3, 3'd3, 1, 0, 1));
        send_request(make_request(REQ_REFRESH, 0, 0, 0, 0, 0, 0, 0));
    endtask

    // small tilts give partial bars; inverted ones fill from the far end
    task automatic test_partial_bars();
        send_request(make_request(REQ_DRAW, 3, 1, 2'd0, 3'd0, 1, 1, 0));
        send_request(make_request(REQ_DRAW, -2, 3, 2'd1, 3'd1, 0, 1, 1));
        send_request(make_request(REQ_DRAW, 1, -3, 2'd2, 3'd2, 1, 0, 1));
        send_request(make_request(REQ_DRAW, 0, 0, 2'd3, 3'd3, 0, 1, 0));
        send_request(make_request(REQ_REFRESH, 0, 0, 0, 0, 0, 0, 0));
    endtask

    // draws past the chain and the unused code leave the frames alone
    task automatic test_dropped_requests();
        send_request(make_request(REQ_DRAW, 16'sh7FFF, 0, 2'd0, 3'(DEVICES), 1, 0, 0));
        send_request(make_request(REQ_DRAW, -1, -1, 2'd3, 3'd7, 0, 1, 1));
        send_request(make_request(REQ_UNUSED, 16'sh7FFF, -16'sh8000, 2'd3, 3'd0, 1, 1, 1));
        send_request(make_request(REQ_REFRESH, 0, 0, 0, 0, 0, 0, 0));
    endtask

    task automatic test_clear_frame();
        send_request(make_request(REQ_CLEAR, 0, 0, 0, 0, 0, 0, 0));
        send_request(make_request(REQ_REFRESH, 0, 0, 0, 0, 0, 0, 0));
    endtask

    task automatic test_random_traffic(input int count);
        for (int n = 0; n < count; n++)
            send_request(random_request());
    endtask

    // -----------------------------------------------------------------------
    // Sequence
    // -----------------------------------------------------------------------
    initial
    begin
        req_ch.valid = 1'b0;
        req_ch.req_type = REQ_DRAW;
        req_ch.tilt_x = '0;
        req_ch.tilt_y = '0;
        req_ch.wall_side = '0;
        req_ch.display_index = '0;
        req_ch.bars_in_rows = 1'b0;
        req_ch.invert_fill = 1'b0;
        req_ch.reverse_order = 1'b0;
        foreach (frame_copy[d, row])
            frame_copy[d][row] = 8'h00;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // slow receiver
        send_idle_pct = 12;
        recv_idle_pct = 86;
        test_refresh_after_reset();
        test_full_tilt_bars();
        test_partial_bars();
        test_dropped_requests();
        test_clear_frame();
        test_random_traffic(110);

        // slow sender
        send_idle_pct = 86;
        recv_idle_pct = 12;
        test_random_traffic(110);

        // back to back
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(110);
        req_ch.valid = 1'b0;

        while (refresh_words_due.size() != 0)
            @(posedge clk);
        // room for a late stray word after the last draw
        repeat (40) @(posedge clk);

        $display("Requests: %0d draws, %0d clears, %0d refreshes, %0d dropped codes",
                 draws_sent, clears_sent, refreshes_sent, dropped_sent);
        $display("Serial words checked: %0d, failures: %0d", words_checked, failures);
        if (failures == 0 && refresh_words_due.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // watchdog
    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Timeout after %0d cycles", cycles);
        $display("Verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+src
src/tbfe_pkg.sv
src/tbfe_req_if.sv
src/tbfe_word_if.sv
src/tbfe_front.sv
src/tbfe_queue.sv
src/tbfe_back.sv
src/tilt_bar_frame_engine_core.sv
dv/tilt_bar_frame_engine_core_test.sv
